// ----- hw/rtl/lfp_pkg.sv -----
// Package for the linked-list free pool: sizes, field widths, operation
// and status codes shared by the interfaces and the top level.
// Depends on nothing.
`default_nettype none
package lfp_pkg;

  localparam int POOL_ENTRIES = 64;
  localparam int USER_LISTS   = 4;

  localparam int IDX_W  = 6;  // entry index
  localparam int CNT_W  = 7;  // counts and pool size
  localparam int LIST_W = 2;  // list select
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  localparam int FREE_MAX = 127;  // free_count saturation

  typedef enum logic [MODE_W-1:0] {
    MODE_INIT       = 3'd0,
    MODE_ALLOC      = 3'd1,
    MODE_RELEASE    = 3'd2,
    MODE_PUSH_BACK  = 3'd3,
    MODE_PUSH_FRONT = 3'd4,
    MODE_POP_FRONT  = 3'd5,
    MODE_REMOVE     = 3'd6,
    MODE_COUNT      = 3'd7
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_RANGE = 2'd2
  } status_e;

endpackage
`default_nettype wire

// ----- hw/rtl/lfp_req_if.sv -----
// Request channel of the linked-list free pool: valid/ready and one
// operation item. Depends on lfp_pkg.
`default_nettype none
interface lfp_req_if;
  logic                        valid;
  logic                        ready;
  logic [lfp_pkg::MODE_W-1:0]  mode;
  logic [lfp_pkg::LIST_W-1:0]  list_id;
  logic [lfp_pkg::IDX_W-1:0]   entry;
  logic [lfp_pkg::IDX_W-1:0]   prior_entry;
  logic                        prior_valid;

  modport source (output valid, mode, list_id, entry, prior_entry, prior_valid,
                  input ready);
  modport sink   (input valid, mode, list_id, entry, prior_entry, prior_valid,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/lfp_rsp_if.sv -----
// Response channel of the linked-list free pool: valid/ready and one
// result item. Depends on lfp_pkg.
`default_nettype none
interface lfp_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lfp_pkg::IDX_W-1:0]   result_entry;
  logic                        found;
  logic [lfp_pkg::CNT_W-1:0]   free_count;
  logic [lfp_pkg::STAT_W-1:0]  status;

  modport source (output valid, result_entry, found, free_count, status,
                  input ready);
  modport sink   (input valid, result_entry, found, free_count, status,
                  output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/linked_list_free_pool.sv -----
// Linked-list free pool: one result item per request item. Throughput is one
// item per cycle unless rsp.ready holds the result stage; the next-pointer
// memory is read at acceptance with an address taken from the state as the
// item ahead leaves it, and a write in that same edge is forwarded into the
// read data. Reset clears lists and free-list state and sets the pool size
// to POOL_MAX; the next-pointer memory is not cleared and needs no clearing
// pass. Depends on lfp_pkg, lfp_req_if and lfp_rsp_if.
`default_nettype none
module linked_list_free_pool (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [lfp_pkg::CNT_W-1:0]  cfg_wdata_i,
  lfp_req_if.sink                         req,
  lfp_rsp_if.source                       rsp
);

  localparam int IW = lfp_pkg::IDX_W;
  localparam int CW = lfp_pkg::CNT_W;
  localparam int LW = lfp_pkg::LIST_W;
  localparam int UL = lfp_pkg::USER_LISTS;

  localparam logic [CW-1:0] POOL_MAX = CW'(lfp_pkg::POOL_ENTRIES);

  // configuration
  logic [CW-1:0] pool_size_q;

  // list and free-list state
  logic [IW-1:0] list_head_q [UL];
  logic [IW-1:0] list_tail_q [UL];
  logic [UL-1:0] list_nonempty_q;
  logic [IW-1:0] freed_head_q;
  logic [CW-1:0] freed_length_q;
  logic [CW-1:0] fresh_index_q;

  logic [IW-1:0] list_head_d [UL];
  logic [IW-1:0] list_tail_d [UL];
  logic [UL-1:0] list_nonempty_d;
  logic [IW-1:0] freed_head_d;
  logic [CW-1:0] freed_length_d;
  logic [CW-1:0] fresh_index_d;

  // next-pointer memory
  logic [IW-1:0] next_mem [lfp_pkg::POOL_ENTRIES];
  logic          mem_we;
  logic [IW-1:0] mem_waddr;
  logic [IW-1:0] mem_wdata;
  logic [IW-1:0] mem_raddr;
  logic [IW-1:0] rdata_q;

  // input stage
  logic           s_valid_q;
  lfp_pkg::mode_e s_mode_q;
  logic [LW-1:0]  s_list_q;
  logic [IW-1:0]  s_entry_q;
  logic [IW-1:0]  s_prior_q;
  logic           s_pv_q;

  // result stage
  logic                r_valid_q;
  logic [IW-1:0]       r_entry_q,  r_entry_d;
  logic                r_found_q,  r_found_d;
  logic [CW-1:0]       r_count_q,  r_count_d;
  lfp_pkg::status_e    r_status_q, r_status_d;

  logic          adv;
  logic          in_acc;
  logic [CW-1:0] pool_eff;
  logic          lid_oor;
  logic          ent_oor;
  logic          pri_oor;
  logic [CW-1:0] avail;
  logic [CW:0]   free_sum;

  assign adv    = s_valid_q && (!r_valid_q || rsp.ready);
  assign in_acc = req.valid && req.ready;
  assign req.ready = !s_valid_q || adv;

  assign pool_eff = (pool_size_q < POOL_MAX) ? pool_size_q : POOL_MAX;
  assign lid_oor  = {1'b0, s_list_q} >= (LW+1)'(UL);
  assign ent_oor  = {1'b0, s_entry_q} >= pool_eff;
  assign pri_oor  = {1'b0, s_prior_q} >= pool_eff;

  // Execute the item in the input stage; state moves only when it advances.
  always_comb begin
    list_head_d     = list_head_q;
    list_tail_d     = list_tail_q;
    list_nonempty_d = list_nonempty_q;
    freed_head_d    = freed_head_q;
    freed_length_d  = freed_length_q;
    fresh_index_d   = fresh_index_q;
    mem_we          = 1'b0;
    mem_waddr       = s_entry_q;
    mem_wdata       = freed_head_q;
    r_entry_d       = '0;
    r_found_d       = 1'b0;
    r_status_d      = lfp_pkg::STATUS_OK;

    if (adv) begin
      if ((s_mode_q == lfp_pkg::MODE_PUSH_BACK || s_mode_q == lfp_pkg::MODE_PUSH_FRONT ||
           s_mode_q == lfp_pkg::MODE_POP_FRONT || s_mode_q == lfp_pkg::MODE_REMOVE) &&
          lid_oor) begin
        r_status_d = lfp_pkg::STATUS_RANGE;
      end else if ((s_mode_q == lfp_pkg::MODE_RELEASE || s_mode_q == lfp_pkg::MODE_PUSH_BACK ||
                    s_mode_q == lfp_pkg::MODE_PUSH_FRONT || s_mode_q == lfp_pkg::MODE_REMOVE) &&
                   (ent_oor || (s_mode_q == lfp_pkg::MODE_REMOVE && s_pv_q && pri_oor))) begin
        r_status_d = lfp_pkg::STATUS_RANGE;
      end else begin
        case (s_mode_q)
          lfp_pkg::MODE_INIT: begin
            freed_head_d   = '0;
            freed_length_d = '0;
            fresh_index_d  = '0;
          end
          lfp_pkg::MODE_ALLOC: begin
            if (freed_length_q != '0) begin
              r_entry_d      = freed_head_q;
              r_found_d      = 1'b1;
              freed_head_d   = rdata_q;
              freed_length_d = freed_length_q - CW'(1);
            end else if (fresh_index_q < pool_eff) begin
              r_entry_d     = fresh_index_q[IW-1:0];
              r_found_d     = 1'b1;
              fresh_index_d = fresh_index_q + CW'(1);
            end else begin
              r_status_d = lfp_pkg::STATUS_EMPTY;
            end
          end
          lfp_pkg::MODE_RELEASE: begin
            mem_we       = 1'b1;
            mem_waddr    = s_entry_q;
            mem_wdata    = freed_head_q;
            freed_head_d = s_entry_q;
            if (freed_length_q < POOL_MAX) begin
              freed_length_d = freed_length_q + CW'(1);
            end
          end
          lfp_pkg::MODE_PUSH_BACK: begin
            if (list_nonempty_q[s_list_q]) begin
              mem_we    = 1'b1;
              mem_waddr = list_tail_q[s_list_q];
              mem_wdata = s_entry_q;
              list_tail_d[s_list_q] = s_entry_q;
            end else begin
              list_head_d[s_list_q]     = s_entry_q;
              list_tail_d[s_list_q]     = s_entry_q;
              list_nonempty_d[s_list_q] = 1'b1;
            end
          end
          lfp_pkg::MODE_PUSH_FRONT: begin
            mem_we    = 1'b1;
            mem_waddr = s_entry_q;
            mem_wdata = list_head_q[s_list_q];
            list_head_d[s_list_q] = s_entry_q;
            if (!list_nonempty_q[s_list_q]) begin
              list_tail_d[s_list_q]     = s_entry_q;
              list_nonempty_d[s_list_q] = 1'b1;
            end
          end
          lfp_pkg::MODE_POP_FRONT: begin
            if (!list_nonempty_q[s_list_q]) begin
              r_status_d = lfp_pkg::STATUS_EMPTY;
            end else begin
              r_entry_d = list_head_q[s_list_q];
              r_found_d = 1'b1;
              if (list_head_q[s_list_q] == list_tail_q[s_list_q]) begin
                list_nonempty_d[s_list_q] = 1'b0;
              end else begin
                list_head_d[s_list_q] = rdata_q;
              end
            end
          end
          lfp_pkg::MODE_REMOVE: begin
            if (!list_nonempty_q[s_list_q]) begin
              r_status_d = lfp_pkg::STATUS_EMPTY;
            end else if (!s_pv_q) begin
              if (s_entry_q == list_tail_q[s_list_q]) begin
                list_nonempty_d[s_list_q] = 1'b0;
              end else begin
                list_head_d[s_list_q] = rdata_q;
              end
            end else begin
              // unlink: prior takes over the removed entry's successor
              if (s_entry_q == list_tail_q[s_list_q]) begin
                list_tail_d[s_list_q] = s_prior_q;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = s_prior_q;
                mem_wdata = rdata_q;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Free count after this item, saturated.
  assign avail     = (pool_eff > fresh_index_d) ? (pool_eff - fresh_index_d) : '0;
  assign free_sum  = {1'b0, freed_length_d} + {1'b0, avail};
  assign r_count_d = (free_sum > (CW+1)'(lfp_pkg::FREE_MAX)) ?
                     CW'(lfp_pkg::FREE_MAX) : free_sum[CW-1:0];

  // Read address of the incoming item, from state as the item ahead leaves it.
  always_comb begin
    case (lfp_pkg::mode_e'(req.mode))
      lfp_pkg::MODE_ALLOC:     mem_raddr = freed_head_d;
      lfp_pkg::MODE_POP_FRONT: mem_raddr = list_head_d[req.list_id];
      default:                 mem_raddr = req.entry;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      next_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      // forward a write landing at the same edge
      rdata_q <= (mem_we && mem_waddr == mem_raddr) ? mem_wdata : next_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_size_q     <= POOL_MAX;
      list_head_q     <= '{default: '0};
      list_tail_q     <= '{default: '0};
      list_nonempty_q <= '0;
      freed_head_q    <= '0;
      freed_length_q  <= '0;
      fresh_index_q   <= '0;
      s_valid_q       <= 1'b0;
      r_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pool_size_q <= cfg_wdata_i;
      end
      list_head_q     <= list_head_d;
      list_tail_q     <= list_tail_d;
      list_nonempty_q <= list_nonempty_d;
      freed_head_q    <= freed_head_d;
      freed_length_q  <= freed_length_d;
      fresh_index_q   <= fresh_index_d;
      if (in_acc) begin
        s_valid_q <= 1'b1;
      end else if (adv) begin
        s_valid_q <= 1'b0;
      end
      if (adv) begin
        r_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        r_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_mode_q  <= lfp_pkg::mode_e'(req.mode);
      s_list_q  <= req.list_id;
      s_entry_q <= req.entry;
      s_prior_q <= req.prior_entry;
      s_pv_q    <= req.prior_valid;
    end
    if (adv) begin
      r_entry_q  <= r_entry_d;
      r_found_q  <= r_found_d;
      r_count_q  <= r_count_d;
      r_status_q <= r_status_d;
    end
  end

  assign rsp.valid        = r_valid_q;
  assign rsp.result_entry = r_entry_q;
  assign rsp.found        = r_found_q;
  assign rsp.free_count   = r_count_q;
  assign rsp.status       = r_status_q;

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_valid_q && r_found_q) |-> (r_status_q == lfp_pkg::STATUS_OK))
    else $error("found result with non-ok status");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_index_q <= POOL_MAX)
    else $error("fresh index above pool capacity");

  a_freed_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    freed_length_q <= POOL_MAX)
    else $error("freed length above pool capacity");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(list_nonempty_q) && $stable(fresh_index_q) &&
              $stable(freed_length_q) && $stable(freed_head_q)))
    else $error("pool state changed without an item advancing");

endmodule
`default_nettype wire
